@@ rtl/tour_swap_cost_engine_assert.svh @@
// Assertion macros for the tour swap cost engine.
// Every macro expects clk_i and rst_ni in the scope where it is used.
`ifndef TOUR_SWAP_COST_ENGINE_ASSERT_SVH
`define TOUR_SWAP_COST_ENGINE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TSCE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TSCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tsce_pkg.sv @@
// Shared constants, codes and control structs for the tour swap cost engine.
// This package has no dependencies.
package tsce_pkg;

  localparam int MAX_CITIES  = 64;
  localparam int CITY_W      = 6;
  localparam int WEIGHT_BITS = 32;
  localparam int IN_WEIGHT_W = 32;
  localparam int SUM_W       = 38;
  localparam int LEN_W       = 7;
  localparam int CMD_W       = 3;
  localparam int WT_ADDR_W   = 2 * CITY_W;
  localparam int WT_DEPTH    = MAX_CITIES * MAX_CITIES;
  localparam int NUM_SLOTS   = 6;
  localparam int NUM_TERMS   = 5;
  localparam int CNT_W       = 4;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam int REG_TOUR_LENGTH = 0;
  localparam logic [LEN_W-1:0] TOUR_LENGTH_RESET = 7'd2;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_SWAP = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_WEIGHT = 3'd0,
    CMD_WRITE_SLOT   = 3'd1,
    CMD_RECOMPUTE    = 3'd2,
    CMD_SWAP         = 3'd3,
    CMD_UNDO         = 3'd4,
    CMD_SWEEP        = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    SRC_CMD   = 2'd0,
    SRC_LAST  = 2'd1,
    SRC_SWEEP = 2'd2
  } pos_src_e;

  typedef struct packed {
    logic     ld_in;
    logic     wt_wr;
    logic     wt_mirror;
    logic     slot_wr;
    logic     rc_start;
    logic     rc_issue;
    logic     pos_ld;
    pos_src_e pos_src;
    logic     tr_issue;
    logic [2:0] slot;
    logic     term_issue;
    logic     after;
    logic [2:0] term;
    logic     acc_from_sum;
    logic     tw_i;
    logic     tw_j;
    logic     upd_swap;
    logic     upd_rc;
    logic     sweep_init;
    logic     sweep_next;
    logic     res_ld;
    logic     res_status;
    logic     res_improved;
  } tsce_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic pos_ok;
    logic swap_known;
    logic lower;
    logic rc_last;
    logic sweep_more;
  } tsce_stat_t;

endpackage

@@ rtl/tsce_in_if.sv @@
// Input channel of the tour swap cost engine: one command per transfer.
// Depends on tsce_pkg for the field widths.
interface tsce_in_if import tsce_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       cmd;
  logic [CITY_W-1:0]      index_a;
  logic [CITY_W-1:0]      index_b;
  logic [CITY_W-1:0]      city_id;
  logic [IN_WEIGHT_W-1:0] edge_weight;

  modport source (output valid, cmd, index_a, index_b, city_id, edge_weight, input ready);
  modport sink   (input valid, cmd, index_a, index_b, city_id, edge_weight, output ready);
endinterface

@@ rtl/tsce_out_if.sv @@
// Result channel of the tour swap cost engine: one result per transfer.
// Depends on tsce_pkg for the field widths.
interface tsce_out_if import tsce_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] path_sum;
  logic             improved;
  logic             status;

  modport source (output valid, path_sum, improved, status, input ready);
  modport sink   (input valid, path_sum, improved, status, output ready);
endinterface

@@ rtl/tsce_ctrl.sv @@
// Sequencer of the tour swap cost engine: decodes commands and steps the datapath.
// Depends on tsce_pkg for the command and status structs.
module tsce_ctrl import tsce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  tsce_stat_t stat_i,
  output tsce_ctl_t  ctl_o
);

  typedef enum logic [14:0] {
    S_IDLE      = 15'b000000000000001,
    S_DECODE    = 15'b000000000000010,
    S_WW2       = 15'b000000000000100,
    S_RC        = 15'b000000000001000,
    S_RC_DRAIN  = 15'b000000000010000,
    S_RC_UPD    = 15'b000000000100000,
    S_SW_CHK    = 15'b000000001000000,
    S_SW_RD     = 15'b000000010000000,
    S_SW_TERM   = 15'b000000100000000,
    S_SW_WR     = 15'b000001000000000,
    S_SW_WR2    = 15'b000010000000000,
    S_SW_UPD    = 15'b000100000000000,
    S_SWP_EVAL  = 15'b001000000000000,
    S_SWP_START = 15'b010000000000000,
    S_FIN       = 15'b100000000000000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             sweep_q, sweep_d;
  logic             ph_q, ph_d;
  logic             fin_st_q, fin_st_d;
  logic             fin_imp_q, fin_imp_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    ctl_o       = '0;
    state_d     = state_q;
    cnt_d       = cnt_q;
    sweep_d     = sweep_q;
    ph_d        = ph_q;
    fin_st_d    = fin_st_q;
    fin_imp_d   = fin_imp_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.ld_in = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        fin_st_d  = STATUS_OK;
        fin_imp_d = 1'b0;
        sweep_d   = 1'b0;
        case (cmd_e'(stat_i.cmd))
          CMD_WRITE_WEIGHT: begin
            ctl_o.wt_wr = 1'b1;
            state_d     = S_WW2;
          end
          CMD_WRITE_SLOT: begin
            ctl_o.slot_wr = 1'b1;
            state_d       = S_FIN;
          end
          CMD_RECOMPUTE: begin
            ctl_o.rc_start = 1'b1;
            state_d        = S_RC;
          end
          CMD_SWAP: begin
            ctl_o.pos_ld  = 1'b1;
            ctl_o.pos_src = SRC_CMD;
            state_d       = S_SW_CHK;
          end
          CMD_UNDO: begin
            if (stat_i.swap_known) begin
              ctl_o.pos_ld  = 1'b1;
              ctl_o.pos_src = SRC_LAST;
              state_d       = S_SW_CHK;
            end else begin
              fin_st_d = STATUS_NO_SWAP;
              state_d  = S_FIN;
            end
          end
          CMD_SWEEP: begin
            ctl_o.sweep_init = 1'b1;
            sweep_d          = 1'b1;
            state_d          = S_SWP_START;
          end
          default: state_d = S_FIN;
        endcase
      end
      S_WW2: begin
        ctl_o.wt_wr     = 1'b1;
        ctl_o.wt_mirror = 1'b1;
        state_d         = S_FIN;
      end
      S_RC: begin
        ctl_o.rc_issue = 1'b1;
        if (stat_i.rc_last) begin
          cnt_d   = '0;
          state_d = S_RC_DRAIN;
        end
      end
      S_RC_DRAIN: begin
        // The drain state lets the last tour read and weight read reach the sum.
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = S_RC_UPD;
        end
      end
      S_RC_UPD: begin
        ctl_o.upd_rc = 1'b1;
        state_d      = S_FIN;
      end
      S_SW_CHK: begin
        if (stat_i.pos_ok) begin
          ctl_o.acc_from_sum = 1'b1;
          cnt_d              = '0;
          state_d            = S_SW_RD;
        end else begin
          state_d = sweep_q ? S_SWP_EVAL : S_FIN;
        end
      end
      S_SW_RD: begin
        if (cnt_q < CNT_W'(NUM_SLOTS)) begin
          ctl_o.tr_issue = 1'b1;
          ctl_o.slot     = cnt_q[2:0];
          cnt_d          = cnt_q + CNT_W'(1);
        end else begin
          cnt_d   = '0;
          state_d = S_SW_TERM;
        end
      end
      S_SW_TERM: begin
        if (cnt_q < CNT_W'(2 * NUM_TERMS)) begin
          ctl_o.term_issue = 1'b1;
          ctl_o.after      = (cnt_q >= CNT_W'(NUM_TERMS));
          ctl_o.term       = ctl_o.after ? 3'(cnt_q - CNT_W'(NUM_TERMS)) : cnt_q[2:0];
          cnt_d            = cnt_q + CNT_W'(1);
        end else begin
          state_d = S_SW_WR;
        end
      end
      S_SW_WR: begin
        ctl_o.tw_i = 1'b1;
        state_d    = S_SW_WR2;
      end
      S_SW_WR2: begin
        ctl_o.tw_j = 1'b1;
        state_d    = S_SW_UPD;
      end
      S_SW_UPD: begin
        ctl_o.upd_swap = 1'b1;
        state_d        = sweep_q ? S_SWP_EVAL : S_FIN;
      end
      S_SWP_START: begin
        if (stat_i.sweep_more) begin
          ctl_o.pos_ld  = 1'b1;
          ctl_o.pos_src = SRC_SWEEP;
          ph_d          = 1'b0;
          state_d       = S_SW_CHK;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SWP_EVAL: begin
        if (!ph_q) begin
          if (stat_i.lower) begin
            fin_imp_d = 1'b1;
            state_d   = S_FIN;
          end else begin
            // The trial did not help: swap the same pair back.
            ph_d    = 1'b1;
            state_d = S_SW_CHK;
          end
        end else begin
          ctl_o.sweep_next = 1'b1;
          state_d          = S_SWP_START;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          ctl_o.res_ld       = 1'b1;
          ctl_o.res_status   = fin_st_q;
          ctl_o.res_improved = fin_imp_q;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.res_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      sweep_q     <= 1'b0;
      ph_q        <= 1'b0;
      fin_st_q    <= STATUS_OK;
      fin_imp_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sweep_q     <= sweep_d;
      ph_q        <= ph_d;
      fin_st_q    <= fin_st_d;
      fin_imp_q   <= fin_imp_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/tsce_dpath.sv @@
// Datapath of the tour swap cost engine: weight and tour memories, sum registers,
// the edge-term accumulator and the result register. Depends on tsce_pkg.
module tsce_dpath import tsce_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tsce_ctl_t              ctl_i,
  output tsce_stat_t             stat_o,
  input  logic [LEN_W-1:0]       tour_length_i,
  input  logic [CMD_W-1:0]       cmd_i,
  input  logic [CITY_W-1:0]      index_a_i,
  input  logic [CITY_W-1:0]      index_b_i,
  input  logic [CITY_W-1:0]      city_id_i,
  input  logic [IN_WEIGHT_W-1:0] edge_weight_i,
  output logic [SUM_W-1:0]       path_sum_o,
  output logic                   improved_o,
  output logic                   status_o
);

  logic [CMD_W-1:0]       cmd_q;
  logic [CITY_W-1:0]      a_q, b_q, city_q;
  logic [IN_WEIGHT_W-1:0] w_q;

  logic [WEIGHT_BITS-1:0] wt_mem [WT_DEPTH];
  logic [WEIGHT_BITS-1:0] wt_rd_q;
  logic [WT_ADDR_W-1:0]   wt_waddr, wt_raddr;
  logic [CITY_W-1:0]      tour_mem [MAX_CITIES];
  logic [CITY_W-1:0]      tour_rd_q;
  logic [CITY_W-1:0]      tour_raddr, tour_waddr, tour_wdata;
  logic                   tour_we;

  logic [SUM_W-1:0]  sum_q, prior_q, acc_q, orig_q;
  logic [CITY_W-1:0] last_i_q, last_j_q;
  logic              known_q;

  logic [CITY_W-1:0] si_q, sj_q;
  logic [LEN_W-1:0]  wi_q, wj_q;
  logic [CITY_W-1:0] p_q;
  logic [CITY_W-1:0] prev_city_q;
  logic [CITY_W-1:0] slot_city_q [NUM_SLOTS];
  logic [CITY_W-1:0] c_eff [NUM_SLOTS];
  logic [CITY_W-1:0] s_pos [NUM_SLOTS];

  logic              rd_v_q, rc_v1_q, rc_first1_q, acc_en_q, acc_sub_q;
  logic [2:0]        rd_slot_q;
  logic              acc_en_d, acc_sub_d;
  logic              term_en;
  logic [CITY_W-1:0] ta, tb;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  si_x, sj_x;

  logic [SUM_W-1:0] res_sum_q;
  logic             res_imp_q, res_st_q;

  // Length below two acts as two, above the table size as the table size.
  always_comb begin
    if (tour_length_i < LEN_W'(2)) begin
      len = LEN_W'(2);
    end else if (tour_length_i > LEN_W'(MAX_CITIES)) begin
      len = LEN_W'(MAX_CITIES);
    end else begin
      len = tour_length_i;
    end
  end

  assign si_x = LEN_W'(si_q);
  assign sj_x = LEN_W'(sj_q);

  // Positions around the swapped pair: i-1, i, i+1, j-1, j, j+1.
  assign s_pos[0] = si_q - CITY_W'(1);
  assign s_pos[1] = si_q;
  assign s_pos[2] = si_q + CITY_W'(1);
  assign s_pos[3] = sj_q - CITY_W'(1);
  assign s_pos[4] = sj_q;
  assign s_pos[5] = sj_q + CITY_W'(1);

  // After the swap, position i holds the old city of j and vice versa.
  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (ctl_i.after && s_pos[s] == si_q) begin
        c_eff[s] = slot_city_q[4];
      end else if (ctl_i.after && s_pos[s] == sj_q) begin
        c_eff[s] = slot_city_q[1];
      end else begin
        c_eff[s] = slot_city_q[s];
      end
    end
  end

  always_comb begin
    case (ctl_i.term)
      3'd0: begin
        ta = c_eff[1]; tb = c_eff[0]; term_en = (si_q != '0);
      end
      3'd1: begin
        ta = c_eff[1]; tb = c_eff[2]; term_en = (si_x + LEN_W'(1) < len);
      end
      3'd2: begin
        ta = c_eff[4]; tb = c_eff[3]; term_en = (sj_q != '0);
      end
      3'd3: begin
        ta = c_eff[4]; tb = c_eff[5]; term_en = (sj_x + LEN_W'(1) < len);
      end
      default: begin
        // Adjacent positions share one edge, counted once.
        ta = c_eff[1]; tb = c_eff[4];
        term_en = (si_x + LEN_W'(1) == sj_x) || (sj_x + LEN_W'(1) == si_x);
      end
    endcase
  end

  always_comb begin
    if (rc_v1_q) begin
      acc_en_d  = !rc_first1_q;
      acc_sub_d = 1'b0;
    end else begin
      acc_en_d  = ctl_i.term_issue && term_en;
      acc_sub_d = (ctl_i.term != 3'(NUM_TERMS - 1)) ^ ctl_i.after;
    end
  end

  assign wt_waddr = ctl_i.wt_mirror ? {b_q, a_q} : {a_q, b_q};
  assign wt_raddr = rc_v1_q ? {prev_city_q, tour_rd_q} : {ta, tb};

  always_ff @(posedge clk_i) begin
    if (ctl_i.wt_wr) begin
      wt_mem[wt_waddr] <= w_q[WEIGHT_BITS-1:0];
    end
    wt_rd_q <= wt_mem[wt_raddr];
  end

  always_comb begin
    tour_we    = ctl_i.slot_wr || ctl_i.tw_i || ctl_i.tw_j;
    tour_waddr = a_q;
    tour_wdata = city_q;
    if (ctl_i.tw_i) begin
      tour_waddr = si_q;
      tour_wdata = slot_city_q[4];
    end else if (ctl_i.tw_j) begin
      tour_waddr = sj_q;
      tour_wdata = slot_city_q[1];
    end
  end

  assign tour_raddr = ctl_i.rc_issue ? p_q : s_pos[ctl_i.slot];

  always_ff @(posedge clk_i) begin
    if (tour_we) begin
      tour_mem[tour_waddr] <= tour_wdata;
    end
    tour_rd_q <= tour_mem[tour_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q      <= 1'b0;
      rc_v1_q     <= 1'b0;
      rc_first1_q <= 1'b0;
      acc_en_q    <= 1'b0;
      acc_sub_q   <= 1'b0;
      sum_q       <= '0;
      prior_q     <= '0;
      last_i_q    <= '0;
      last_j_q    <= '0;
      known_q     <= 1'b0;
    end else begin
      rd_v_q      <= ctl_i.tr_issue;
      rc_v1_q     <= ctl_i.rc_issue;
      rc_first1_q <= (p_q == '0);
      acc_en_q    <= acc_en_d;
      acc_sub_q   <= acc_sub_d;
      if (ctl_i.upd_swap) begin
        prior_q  <= sum_q;
        sum_q    <= acc_q;
        last_i_q <= si_q;
        last_j_q <= sj_q;
        known_q  <= 1'b1;
      end else if (ctl_i.upd_rc) begin
        sum_q <= acc_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_in) begin
      cmd_q  <= cmd_i;
      a_q    <= index_a_i;
      b_q    <= index_b_i;
      city_q <= city_id_i;
      w_q    <= edge_weight_i;
    end
    if (rd_v_q) begin
      slot_city_q[rd_slot_q] <= tour_rd_q;
    end
    rd_slot_q <= ctl_i.slot;
    if (rc_v1_q) begin
      prev_city_q <= tour_rd_q;
    end
    if (ctl_i.rc_start) begin
      p_q <= '0;
    end else if (ctl_i.rc_issue) begin
      p_q <= p_q + CITY_W'(1);
    end
    if (ctl_i.rc_start) begin
      acc_q <= '0;
    end else if (ctl_i.acc_from_sum) begin
      acc_q <= sum_q;
    end else if (acc_en_q) begin
      acc_q <= acc_sub_q ? acc_q - SUM_W'(wt_rd_q) : acc_q + SUM_W'(wt_rd_q);
    end
    if (ctl_i.pos_ld) begin
      case (ctl_i.pos_src)
        SRC_CMD: begin
          si_q <= a_q; sj_q <= b_q;
        end
        SRC_LAST: begin
          si_q <= last_i_q; sj_q <= last_j_q;
        end
        SRC_SWEEP: begin
          si_q <= wi_q[CITY_W-1:0]; sj_q <= wj_q[CITY_W-1:0];
        end
        default: begin
          si_q <= a_q; sj_q <= b_q;
        end
      endcase
    end
    if (ctl_i.sweep_init) begin
      orig_q <= sum_q;
      wi_q   <= '0;
      wj_q   <= LEN_W'(1);
    end else if (ctl_i.sweep_next) begin
      if (wj_q + LEN_W'(1) >= len) begin
        wi_q <= wi_q + LEN_W'(1);
        wj_q <= wi_q + LEN_W'(2);
      end else begin
        wj_q <= wj_q + LEN_W'(1);
      end
    end
    if (ctl_i.res_ld) begin
      res_sum_q <= sum_q;
      res_imp_q <= ctl_i.res_improved;
      res_st_q  <= ctl_i.res_status;
    end
  end

  assign stat_o.cmd        = cmd_q;
  assign stat_o.pos_ok     = (si_x < len) && (sj_x < len);
  assign stat_o.swap_known = known_q;
  assign stat_o.lower      = (sum_q < orig_q);
  assign stat_o.rc_last    = (LEN_W'(p_q) == len - LEN_W'(1));
  assign stat_o.sweep_more = (wi_q + LEN_W'(1) < len);

  assign path_sum_o = res_sum_q;
  assign improved_o = res_imp_q;
  assign status_o   = res_st_q;

endmodule

@@ rtl/tour_swap_cost_engine.sv @@
// Top level of the tour swap cost engine: configuration register, sequencer and datapath.
// Depends on tsce_pkg, tsce_in_if, tsce_out_if, tsce_ctrl, tsce_dpath and the assert header.
//
//   channel   direction  transfer content
//   in_i      sink       cmd, index_a, index_b, city_id, edge_weight
//   out_o     source     path_sum, improved, status
//   apb       slave      tour_length at byte address 0
//
// One command is worked on at a time; the input is taken again once the result sits in
// the output register. Recompute: one tour read per position of the used tour length,
// one per cycle through the tour memory. Swap or undo: six tour reads and ten weight reads
// on single ports. Sweep: a trial pair that lowers the sum is kept and ends the sweep;
// other pairs are swapped back. A result waiting in the output register stalls the next
// result, not the input. No clearing pass after reset.
`include "tour_swap_cost_engine_assert.svh"

module tour_swap_cost_engine import tsce_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tsce_in_if.sink               in_i,
  tsce_out_if.source            out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [LEN_W-1:0] tour_length_q, tour_length_d;
  logic             reg_hit;
  tsce_ctl_t        ctl;
  tsce_stat_t       stat;
  logic             out_valid;

  // Word index sits above the byte lanes.
  assign reg_hit = (paddr[CFG_ADDR_W-1:2] == 1'(REG_TOUR_LENGTH));

  always_comb begin
    tour_length_d = tour_length_q;
    if (psel && penable && pwrite && reg_hit) begin
      tour_length_d = pwdata[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tour_length_q <= TOUR_LENGTH_RESET;
    end else begin
      tour_length_q <= tour_length_d;
    end
  end

  assign prdata = reg_hit ? CFG_DATA_W'(tour_length_q) : '0;
  assign pready = 1'b1;

  tsce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  tsce_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .stat_o        (stat),
    .tour_length_i (tour_length_q),
    .cmd_i         (in_i.cmd),
    .index_a_i     (in_i.index_a),
    .index_b_i     (in_i.index_b),
    .city_id_i     (in_i.city_id),
    .edge_weight_i (in_i.edge_weight),
    .path_sum_o    (out_o.path_sum),
    .improved_o    (out_o.improved),
    .status_o      (out_o.status)
  );

  assign out_o.valid = out_valid;

  `TSCE_ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready, "input taken while busy")
  `TSCE_ASSERT_IMPL(a_commit_in_range, ctl.upd_swap, stat.pos_ok, "swap committed out of range")
  `TSCE_ASSERT_NEXT(a_tour_write_pair, ctl.tw_i, ctl.tw_j, "second tour write missing")

endmodule
